[hw/rtl/fsw_pkg.sv]
// ----------------------------------------------------------------------------
// fsw_pkg: shared definitions for the switch feedback supervisor
// Channel phase codes, configuration indexes, reset values and the
// per-channel status word.
// ----------------------------------------------------------------------------
package fsw_pkg;

    // Channel 0 precharge, 1 charge, 2 discharge.
    localparam int NUM_CHANNELS = 3;

    localparam int TIMEOUT_W = 10;
    localparam int RETRY_W   = 8;
    localparam int CFG_DW    = 10;
    localparam int CFG_IW    = 1;

    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 10'd100;
    localparam logic [RETRY_W-1:0]   RETRY_RESET   = 8'd20;
    localparam logic [RETRY_W-1:0]   MISMATCH_MAX  = 8'hFF;

    // Configuration register indexes.
    localparam logic [CFG_IW-1:0] CFG_TIMEOUT = 1'd0;
    localparam logic [CFG_IW-1:0] CFG_RETRY   = 1'd1;

    // Phase of one channel; codes 2, 5 and 6 are unused.
    typedef enum logic [2:0] {
        PH_CLOSED = 3'd0,
        PH_OPEN   = 3'd1,
        PH_CHECK  = 3'd3,
        PH_SHORT  = 3'd4,
        PH_FAULT  = 3'd7
    } t_phase;

    // Per-channel result of one tick.
    typedef struct packed {
        logic strobe;
        logic level;
        logic retry;
        logic short_wait;
        logic fault;
    } t_chan_status;

endpackage

[hw/rtl/fsw_in_if.sv]
// ----------------------------------------------------------------------------
// fsw_in_if: control tick channel
// Commanded states, switch feedback and the short-circuit warning.
// ----------------------------------------------------------------------------
interface fsw_in_if;
    logic valid;
    logic ready;
    logic cmd_pre;
    logic cmd_chg;
    logic cmd_dsg;
    logic fb_pre;
    logic fb_chg;
    logic fb_dsg;
    logic short_warn;

    modport source (
        output valid, cmd_pre, cmd_chg, cmd_dsg, fb_pre, fb_chg, fb_dsg, short_warn,
        input  ready
    );
    modport sink (
        input  valid, cmd_pre, cmd_chg, cmd_dsg, fb_pre, fb_chg, fb_dsg, short_warn,
        output ready
    );
endinterface

[hw/rtl/fsw_out_if.sv]
// ----------------------------------------------------------------------------
// fsw_out_if: supervisor result channel
// Drive strobes and levels, retry events, short waits and fault flags.
// ----------------------------------------------------------------------------
interface fsw_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] drive_strobe;
    logic [2:0] drive_value;
    logic [2:0] retry_event;
    logic [2:0] short_wait;
    logic [2:0] fault;

    modport source (
        output valid, drive_strobe, drive_value, retry_event, short_wait, fault,
        input  ready
    );
    modport sink (
        input  valid, drive_strobe, drive_value, retry_event, short_wait, fault,
        output ready
    );
endinterface

[hw/rtl/fet_switch_feedback_supervisor.sv]
// ----------------------------------------------------------------------------
// fet_switch_feedback_supervisor: power switch feedback supervisor
// Three per-channel state machines compare commanded switch states with
// feedback, reissue drives, time out, retry and latch faults.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Word
//  i_in     in         cmd_pre/chg/dsg, fb_pre/chg/dsg, short_warn
//  o_out    out        drive_strobe, drive_value, retry_event, short_wait, fault
//  i_cfg_*  in         register index and data, write enable
//
//  One word per cycle unless the output is stalled: a tick updates the channel
//  state registers and is loaded into the output register at the edge it is
//  accepted, so its result is offered in the next cycle. The output register
//  alone parts the two sides: a new tick is taken whenever the output register
//  is empty or being read. Synchronous reset puts every channel in the closed
//  phase with clear counters and restores the register defaults.
//
module fet_switch_feedback_supervisor (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    fsw_in_if.sink                        i_in,
    fsw_out_if.source                     o_out,
    input  logic                          i_cfg_wr_en,
    input  logic [fsw_pkg::CFG_IW-1:0]    i_cfg_idx,
    input  logic [fsw_pkg::CFG_DW-1:0]    i_cfg_data
);

    localparam int NC = fsw_pkg::NUM_CHANNELS;

    logic [fsw_pkg::TIMEOUT_W-1:0]  r_timeout;
    logic [fsw_pkg::RETRY_W-1:0]    r_retry_limit;
    logic [fsw_pkg::TIMEOUT_W-1:0]  limit_t;

    logic                           advance;
    logic                           in_ready;
    logic [NC-1:0]                  cmd_vec;
    logic [NC-1:0]                  fb_vec;
    fsw_pkg::t_chan_status          status [NC];

    logic [NC-1:0]                  n_strobe, n_value, n_retry, n_wait, n_fault;
    logic                           r_out_valid;
    logic [NC-1:0]                  r_strobe, r_value, r_retry, r_wait, r_fault;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout     <= fsw_pkg::TIMEOUT_RESET;
            r_retry_limit <= fsw_pkg::RETRY_RESET;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_idx)
                fsw_pkg::CFG_TIMEOUT: r_timeout     <= i_cfg_data[fsw_pkg::TIMEOUT_W-1:0];
                fsw_pkg::CFG_RETRY:   r_retry_limit <= i_cfg_data[fsw_pkg::RETRY_W-1:0];
                default:              r_timeout     <= r_timeout;
            endcase
        end
    end

    // A zero timeout behaves as one tick.
    assign limit_t = (r_timeout == '0) ? fsw_pkg::TIMEOUT_W'(1) : r_timeout;

    // Handshake: take a word whenever the output register can move.
    assign in_ready   = !r_out_valid || o_out.ready;
    assign advance    = i_in.valid && in_ready;
    assign i_in.ready = in_ready;

    assign cmd_vec = {i_in.cmd_dsg, i_in.cmd_chg, i_in.cmd_pre};
    assign fb_vec  = {i_in.fb_dsg,  i_in.fb_chg,  i_in.fb_pre};

    // One state machine per switch.
    for (genvar g = 0; g < NC; g++) begin : g_chan
        fsw_channel u_chan (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_advance     (advance),
            .i_cmd         (cmd_vec[g]),
            .i_fb          (fb_vec[g]),
            .i_warn        (i_in.short_warn),
            .i_limit       (limit_t),
            .i_retry_limit (r_retry_limit),
            .o_status      (status[g])
        );
        assign n_strobe[g] = status[g].strobe;
        assign n_value[g]  = status[g].level;
        assign n_retry[g]  = status[g].retry;
        assign n_wait[g]   = status[g].short_wait;
        assign n_fault[g]  = status[g].fault;
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_strobe <= n_strobe;
            r_value  <= n_value;
            r_retry  <= n_retry;
            r_wait   <= n_wait;
            r_fault  <= n_fault;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.drive_strobe = r_strobe;
    assign o_out.drive_value  = r_value;
    assign o_out.retry_event  = r_retry;
    assign o_out.short_wait   = r_wait;
    assign o_out.fault        = r_fault;

endmodule

[hw/rtl/fsw_channel.sv]
// ----------------------------------------------------------------------------
// fsw_channel: state machine of one power switch
// Holds the phase, the pending tick counter and the mismatch counter, and
// advances them by one control tick when i_advance is high.
// ----------------------------------------------------------------------------
module fsw_channel (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_advance,
    input  logic                              i_cmd,
    input  logic                              i_fb,
    input  logic                              i_warn,
    input  logic [fsw_pkg::TIMEOUT_W-1:0]     i_limit,
    input  logic [fsw_pkg::RETRY_W-1:0]       i_retry_limit,
    output fsw_pkg::t_chan_status             o_status
);

    fsw_pkg::t_phase                  r_phase, n_phase;
    logic [fsw_pkg::TIMEOUT_W-1:0]    r_pending, n_pending;
    logic [fsw_pkg::RETRY_W-1:0]      r_mismatch, n_mismatch;

    logic                             want;
    logic                             drive_match;
    logic [fsw_pkg::TIMEOUT_W-1:0]    pend_inc;
    logic [fsw_pkg::TIMEOUT_W-1:0]    pend_step;
    logic [fsw_pkg::RETRY_W-1:0]      mis_sat;
    logic                             timed_out;
    logic                             limit_hit;

    // Shared terms: the level this phase drives toward and the counter steps.
    assign want        = (r_phase == fsw_pkg::PH_CLOSED);
    assign drive_match = (i_cmd == want);
    assign pend_inc    = r_pending + 1'b1;
    assign pend_step   = (i_fb == want) ? '0 : pend_inc;
    assign timed_out   = (pend_step >= i_limit);
    assign mis_sat     = (r_mismatch < fsw_pkg::MISMATCH_MAX) ? r_mismatch + 1'b1
                                                              : r_mismatch;
    assign limit_hit   = (mis_sat >= i_retry_limit);

    // Next phase.
    always_comb begin
        n_phase = r_phase;
        unique case (r_phase)
            fsw_pkg::PH_CLOSED, fsw_pkg::PH_OPEN: begin
                if (drive_match) begin
                    if (timed_out) begin
                        n_phase = fsw_pkg::PH_CHECK;
                    end else if (i_fb == want) begin
                        n_phase = want ? fsw_pkg::PH_OPEN : fsw_pkg::PH_CLOSED;
                    end
                end
            end
            fsw_pkg::PH_CHECK: begin
                if (i_warn) begin
                    n_phase = fsw_pkg::PH_SHORT;
                end else if (limit_hit) begin
                    n_phase = fsw_pkg::PH_FAULT;
                end else begin
                    n_phase = i_fb ? fsw_pkg::PH_OPEN : fsw_pkg::PH_CLOSED;
                end
            end
            fsw_pkg::PH_SHORT: begin
                if (!i_warn) begin
                    n_phase = fsw_pkg::PH_CLOSED;
                end
            end
            default: begin
                n_phase = r_phase;
            end
        endcase
    end

    // Counters and per-tick outputs.
    always_comb begin
        n_pending  = r_pending;
        n_mismatch = r_mismatch;
        o_status   = '0;
        unique case (r_phase)
            fsw_pkg::PH_CLOSED, fsw_pkg::PH_OPEN: begin
                if (drive_match) begin
                    o_status.strobe = 1'b1;
                    o_status.level  = want;
                    n_pending       = timed_out ? '0 : pend_step;
                    if (i_fb == want) begin
                        n_mismatch = '0;
                    end
                end
            end
            fsw_pkg::PH_CHECK: begin
                if (!i_warn) begin
                    o_status.retry = 1'b1;
                    n_mismatch     = mis_sat;
                end
            end
            default: begin
                n_pending = r_pending;
            end
        endcase
        o_status.short_wait = (n_phase == fsw_pkg::PH_SHORT);
        o_status.fault      = (n_phase == fsw_pkg::PH_FAULT);
    end

    // State registers advance once per accepted tick.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= fsw_pkg::PH_CLOSED;
            r_pending  <= '0;
            r_mismatch <= '0;
        end else if (i_advance) begin
            r_phase    <= n_phase;
            r_pending  <= n_pending;
            r_mismatch <= n_mismatch;
        end
    end

endmodule
